[sv/cfla_pkg.sv]
// Shared types and constants for the chunked free-list slot id allocator.
package cfla_pkg;

    // Field widths fixed by the request, result and register port formats
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 17;
    localparam int CHUNK_W  = 17;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLR_FLAG  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLR_ALL   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FREE  = 2'd3;

    // Register indexes
    localparam logic REG_FIRST_CHUNK = 1'b0;
    localparam logic REG_GROW_CHUNK  = 1'b1;

    // Register reset values
    localparam logic [CHUNK_W-1:0] FIRST_CHUNK_RST = 17'd4048;
    localparam logic [CHUNK_W-1:0] GROW_CHUNK_RST  = 17'd1024;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] release_id;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_id;
        logic [STATUS_W-1:0] status;
        logic [CAP_W-1:0]    capacity;
        logic                realloc_flag;
    } rsp_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] first_chunk;
        logic [CHUNK_W-1:0] grow_chunk;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
    } ctrl_cmd_t;

endpackage

[sv/chunked_free_list_id_allocator_unit.sv]
// Top level of the chunked free-list slot id allocator.
// A request accepted from idle passes the read and execute states; its result strobe (done)
// is registered from execute. No new request is taken until the last is through, as the stack
// and allocated-bit memories are read registered between the read and execute steps; busy is high meanwhile.
// Reset: counters, capacity and flag clear at once; no memory clearing pass is needed.
// The result appears on rsp with done, which is high for one cycle; the receiver cannot stall it.
module chunked_free_list_id_allocator_unit #(
    parameter int MAX_IDS = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cfla_pkg::req_t                req,
    output logic                          done,
    output cfla_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfla_pkg::PADDR_W-1:0]  paddr,
    input  logic [cfla_pkg::DATA_W-1:0]   pwdata,
    output logic [cfla_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import cfla_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;

    // Configuration registers
    cfla_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller
    cfla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Datapath
    cfla_dp #(
        .MAX_IDS (MAX_IDS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .cfg   (cfg),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

[sv/cfla_ram.sv]
// Generic simple dual-port RAM with registered read.
module cfla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/cfla_regs.sv]
// Configuration register bank behind the APB-style port.
module cfla_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfla_pkg::PADDR_W-1:0]    paddr,
    input  logic [cfla_pkg::DATA_W-1:0]     pwdata,
    output logic [cfla_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    output cfla_pkg::cfg_t                  cfg
);
    import cfla_pkg::*;

    logic [CHUNK_W-1:0] first_chunk_reg, first_chunk_next;
    logic [CHUNK_W-1:0] grow_chunk_reg, grow_chunk_next;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Write decode
    always_comb
    begin
        first_chunk_next = first_chunk_reg;
        grow_chunk_next  = grow_chunk_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_FIRST_CHUNK: first_chunk_next = pwdata[CHUNK_W-1:0];
                REG_GROW_CHUNK:  grow_chunk_next  = pwdata[CHUNK_W-1:0];
                default:         first_chunk_next = first_chunk_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_chunk_reg <= FIRST_CHUNK_RST;
            grow_chunk_reg  <= GROW_CHUNK_RST;
        end
        else
        begin
            first_chunk_reg <= first_chunk_next;
            grow_chunk_reg  <= grow_chunk_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_FIRST_CHUNK: prdata = DATA_W'(first_chunk_reg);
            REG_GROW_CHUNK:  prdata = DATA_W'(grow_chunk_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.first_chunk = first_chunk_reg;
    assign cfg.grow_chunk  = grow_chunk_reg;

endmodule

[sv/cfla_ctrl.sv]
// Sequencing state machine: load, memory read, execute.
module cfla_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output cfla_pkg::ctrl_cmd_t  cmd
);
    import cfla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath
    assign busy     = (state_reg != S_IDLE);
    assign cmd.load = (state_reg == S_IDLE) & start;
    assign cmd.rd   = (state_reg == S_READ);
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

[sv/cfla_dp.sv]
// Allocator datapath: counters, free stack and allocated-bit memories.
module cfla_dp #(
    parameter int MAX_IDS = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfla_pkg::ctrl_cmd_t  cmd,
    input  cfla_pkg::req_t       req,
    input  cfla_pkg::cfg_t       cfg,
    output logic                 done,
    output cfla_pkg::rsp_t       rsp
);
    import cfla_pkg::*;

    localparam int ID_W  = $clog2(MAX_IDS);
    localparam int CNT_W = $clog2(MAX_IDS + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int SUM_W = ((CNT_W > CHUNK_W) ? CNT_W : CHUNK_W) + 1;

    logic [OP_W-1:0]   op_reg;
    logic [SLOT_W-1:0] rid_reg;
    logic [CNT_W-1:0]  stack_count_reg, stack_count_next;
    logic [CNT_W-1:0]  next_fresh_reg, next_fresh_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic              grew_reg, grew_next;
    logic              done_reg;
    rsp_t              rsp_reg, rsp_next;

    logic              stk_we;
    logic [ID_W-1:0]   stk_raddr;
    logic [ID_W-1:0]   stk_rdata;
    logic              bit_we;
    logic [ID_W-1:0]   bit_waddr;
    logic              bit_wdata;
    logic [ID_W-1:0]   bit_raddr;
    logic              bit_rdata;

    logic [CHUNK_W-1:0] chunk_sel;
    logic [CHUNK_W-1:0] chunk_eff;
    logic [SUM_W-1:0]   cap_sum;
    logic [CNT_W-1:0]   cap_grown;
    logic [CMP_W-1:0]   rid_ext;
    logic               in_range;
    logic               ever_given;
    logic [ID_W-1:0]    alloc_id;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.op;
            rid_reg <= req.release_id;
        end
    end

    // Read addresses: top of stack, and the allocated bit of the released id
    assign stk_raddr = ID_W'(stack_count_reg - CNT_W'(1));
    assign bit_raddr = ID_W'(rid_reg);

    cfla_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_IDS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (ID_W'(stack_count_reg)),
        .wdata (ID_W'(rid_reg)),
        .re    (cmd.rd),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    cfla_ram #(
        .WIDTH (1),
        .DEPTH (MAX_IDS)
    ) u_alloc_ram (
        .clk   (clk),
        .we    (bit_we),
        .waddr (bit_waddr),
        .wdata (bit_wdata),
        .re    (cmd.rd),
        .raddr (bit_raddr),
        .rdata (bit_rdata)
    );

    // Capacity growth: chunk of zero counts as one, clamp at the id limit
    assign chunk_sel = (cap_reg == '0) ? cfg.first_chunk : cfg.grow_chunk;
    assign chunk_eff = (chunk_sel == '0) ? CHUNK_W'(1) : chunk_sel;
    assign cap_sum   = SUM_W'(cap_reg) + SUM_W'(chunk_eff);
    assign cap_grown = (cap_sum > SUM_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : CNT_W'(cap_sum);

    // Release checks; ids at or above next_fresh were never handed out
    // since the last clear, so their allocated bit is ignored and they count as free
    assign rid_ext    = CMP_W'(rid_reg);
    assign in_range   = rid_ext < CMP_W'(cap_reg);
    assign ever_given = rid_ext < CMP_W'(next_fresh_reg);

    // Execute step
    always_comb
    begin
        stack_count_next = stack_count_reg;
        next_fresh_next  = next_fresh_reg;
        cap_next         = cap_reg;
        grew_next        = grew_reg;
        stk_we           = 1'b0;
        bit_we           = 1'b0;
        bit_waddr        = bit_raddr;
        bit_wdata        = 1'b0;
        alloc_id         = ID_W'(next_fresh_reg);
        rsp_next.slot_id = '0;
        rsp_next.status  = ST_OK;
        if (cmd.exec)
        begin
            unique case (op_reg)
                OP_ALLOC:
                begin
                    if (stack_count_reg != '0)
                    begin
                        alloc_id         = stk_rdata;
                        stack_count_next = stack_count_reg - CNT_W'(1);
                        bit_we           = 1'b1;
                    end
                    else if (next_fresh_reg < cap_reg)
                    begin
                        next_fresh_next = next_fresh_reg + CNT_W'(1);
                        bit_we          = 1'b1;
                    end
                    else if (cap_grown != cap_reg)
                    begin
                        cap_next        = cap_grown;
                        grew_next       = 1'b1;
                        next_fresh_next = next_fresh_reg + CNT_W'(1);
                        bit_we          = 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    bit_waddr = alloc_id;
                    bit_wdata = 1'b1;
                    if (bit_we)
                    begin
                        rsp_next.slot_id = SLOT_W'(alloc_id);
                    end
                end
                OP_RELEASE:
                begin
                    if (!in_range)
                    begin
                        rsp_next.status = ST_RANGE;
                    end
                    else if (!(ever_given && bit_rdata))
                    begin
                        rsp_next.status = ST_FREE;
                    end
                    else
                    begin
                        bit_we = 1'b1;
                        if (stack_count_reg < CNT_W'(MAX_IDS))
                        begin
                            stk_we           = 1'b1;
                            stack_count_next = stack_count_reg + CNT_W'(1);
                        end
                    end
                end
                OP_CLR_FLAG:
                begin
                    grew_next = 1'b0;
                end
                OP_CLR_ALL:
                begin
                    stack_count_next = '0;
                    next_fresh_next  = '0;
                    cap_next         = '0;
                    grew_next        = 1'b0;
                end
                default:
                begin
                    grew_next = grew_reg;
                end
            endcase
        end
        rsp_next.capacity     = CAP_W'(cap_next);
        rsp_next.realloc_flag = grew_next;
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= '0;
            next_fresh_reg  <= '0;
            cap_reg         <= '0;
            grew_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            stack_count_reg <= stack_count_next;
            next_fresh_reg  <= next_fresh_next;
            cap_reg         <= cap_next;
            grew_reg        <= grew_next;
            done_reg        <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[tb/sv/cfla_alloc_checker.sv]
// Checker for the slot id allocator: mirrors its state from the requests and checks each result.
`timescale 1ns / 100ps

module cfla_alloc_checker #(
    parameter int MAX_IDS = 65536
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  cfla_pkg::req_t               req,
    input  logic                         done,
    input  cfla_pkg::rsp_t               rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cfla_pkg::PADDR_W-1:0] paddr,
    input  logic [cfla_pkg::DATA_W-1:0]  pwdata,
    input  logic [cfla_pkg::DATA_W-1:0]  prdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           pending_count
);
    import cfla_pkg::*;

    // Mirrored chunk registers
    logic [CHUNK_W-1:0] first_chunk_cfg;
    logic [CHUNK_W-1:0] grow_chunk_cfg;

    // Mirrored allocator state
    logic [SLOT_W-1:0] released_ids[$];
    logic [CAP_W-1:0]  fresh_next;
    logic [CAP_W-1:0]  cap_cur;
    bit                id_held [MAX_IDS];
    logic              grown;

    // Results still owed by the block, oldest first
    rsp_t expected_results[$];

    task automatic report_mismatch(input string what);
        if (fail_count < 100)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        fail_count++;
    endtask

    // Empty the stack, forget every handed-out id, and clear the capacity and growth flag
    function automatic void wipe_ids();
        released_ids.delete();
        fresh_next = '0;
        cap_cur    = '0;
        grown      = 1'b0;
        foreach (id_held[i])
        begin
            id_held[i] = 1'b0;
        end
    endfunction

    // Work out the result of one request and move the mirrored state on
    function automatic rsp_t predict_slot_result(input req_t r);
        rsp_t        res;
        int unsigned chunk;
        int unsigned grown_cap;
        res        = '0;
        res.status = ST_OK;
        case (r.op)
            OP_ALLOC:
            begin
                if (released_ids.size() > 0)
                begin
                    // most recently released id goes out first
                    res.slot_id = released_ids[released_ids.size() - 1];
                    released_ids.delete(released_ids.size() - 1);
                    id_held[res.slot_id] = 1'b1;
                end
                else
                begin
                    if (fresh_next >= cap_cur)
                    begin
                        chunk = (cap_cur == 0) ? first_chunk_cfg : grow_chunk_cfg;
                        if (chunk == 0)
                        begin
                            chunk = 1;
                        end
                        grown_cap = cap_cur + chunk;
                        if (grown_cap > MAX_IDS)
                        begin
                            grown_cap = MAX_IDS;
                        end
                        if (grown_cap > cap_cur)
                        begin
                            cap_cur = CAP_W'(grown_cap);
                            grown   = 1'b1;
                        end
                        else
                        begin
                            res.status = ST_FULL;
                        end
                    end
                    if (res.status == ST_OK)
                    begin
                        res.slot_id = fresh_next[SLOT_W-1:0];
                        id_held[res.slot_id] = 1'b1;
                        fresh_next++;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (r.release_id >= cap_cur)
                begin
                    res.status = ST_RANGE;
                end
                else if (!id_held[r.release_id])
                begin
                    res.status = ST_FREE;
                end
                else
                begin
                    id_held[r.release_id] = 1'b0;
                    released_ids.insert(released_ids.size(), r.release_id);
                end
            end
            OP_CLR_FLAG:
            begin
                grown = 1'b0;
            end
            default:
            begin
                wipe_ids();
            end
        endcase
        res.capacity     = cap_cur;
        res.realloc_flag = grown;
        return res;
    endfunction

    // Watch register port, result strobe and request handshake at each edge
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        logic [CHUNK_W-1:0] reg_value;
        if (!rst_n)
        begin
            first_chunk_cfg = FIRST_CHUNK_RST;
            grow_chunk_cfg  = GROW_CHUNK_RST;
            wipe_ids();
            expected_results.delete();
        end
        else
        begin
            // register access phase on an aligned address
            if (psel && penable && pready && paddr[1:0] == 2'b00)
            begin
                reg_value = (paddr[2] == REG_FIRST_CHUNK) ? first_chunk_cfg : grow_chunk_cfg;
                if (pwrite)
                begin
                    if (paddr[2] == REG_FIRST_CHUNK)
                        first_chunk_cfg = pwdata[CHUNK_W-1:0];
                    else
                        grow_chunk_cfg = pwdata[CHUNK_W-1:0];
                end
                else if (prdata !== DATA_W'(reg_value))
                begin
                    report_mismatch($sformatf("register %0d read %0h, want %0h",
                                              paddr[2], prdata, reg_value));
                end
            end

            // compare a finished request with the oldest prediction
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result strobe with no request outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.slot_id !== want.slot_id)
                        report_mismatch($sformatf("slot_id %0d, want %0d",
                                                  rsp.slot_id, want.slot_id));
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  rsp.status, want.status));
                    if (rsp.capacity !== want.capacity)
                        report_mismatch($sformatf("capacity %0d, want %0d",
                                                  rsp.capacity, want.capacity));
                    if (rsp.realloc_flag !== want.realloc_flag)
                        report_mismatch($sformatf("realloc_flag %0b, want %0b",
                                                  rsp.realloc_flag, want.realloc_flag));
                end
            end

            // new request taken by the block
            if (start && !busy)
            begin
                want = predict_slot_result(req);
                expected_results.insert(expected_results.size(), want);
            end
        end
        pending_count = expected_results.size();
    end

endmodule

[tb/sv/chunked_free_list_id_allocator_unit_test.sv]
// Top of the slot id allocator testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 100ps

module chunked_free_list_id_allocator_unit_test;
    import cfla_pkg::*;

    localparam int MAX_IDS       = 65536;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 6;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    req_t               req     = '0;
    logic               done;
    rsp_t               rsp;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 fail_count;
    int                 pending_count;
    int                 accepted_count = 0;
    int                 cycle_count    = 0;
    logic [CAP_W-1:0]   cap_seen       = '0;
    logic [SLOT_W-1:0]  recent_ids[$];

    chunked_free_list_id_allocator_unit #(
        .MAX_IDS (MAX_IDS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cfla_alloc_checker #(
        .MAX_IDS (MAX_IDS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .done          (done),
        .rsp           (rsp),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #6 clk = ~clk;

    // Count cycles and accepted requests, and keep recent ids and capacity for release targets
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (start && !busy)
        begin
            accepted_count <= accepted_count + 1;
        end
        if (done)
        begin
            cap_seen <= rsp.capacity;
            if (rsp.status == ST_OK)
            begin
                recent_ids.insert(recent_ids.size(), rsp.slot_id);
                if (recent_ids.size() > 16)
                    void'(recent_ids.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("chunked_free_list_id_allocator_unit regression: fail");
            $finish;
        end
    end

    // Mostly short idle gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Present one request and hold it until the block takes it
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] id,
                                 input int unsigned gap);
        req_t r;
        int   mark;
        r.op         = op;
        r.release_id = id;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        mark  = accepted_count;
        @(negedge clk);
        while (accepted_count == mark)
            @(negedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_requests(input int unsigned settle);
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // One register transfer: setup, access, then idle; upper data bits are junk
    task automatic apb_access(input logic write, input logic idx, input logic [CHUNK_W-1:0] value);
        logic [DATA_W-1:0] word;
        word = $urandom();
        word[CHUNK_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write both chunk registers while idle, then read them back
    task automatic set_chunks(input logic [CHUNK_W-1:0] first, input logic [CHUNK_W-1:0] grow);
        drain_requests(SETTLE_CYCLES);
        apb_access(1'b1, REG_FIRST_CHUNK, first);
        apb_access(1'b1, REG_GROW_CHUNK, grow);
        apb_access(1'b0, REG_FIRST_CHUNK, '0);
        apb_access(1'b0, REG_GROW_CHUNK, '0);
    endtask

    // Random request: releases mostly aim at ids recently handed out or up to just past capacity
    task automatic issue_random();
        int unsigned       roll;
        int unsigned       pick;
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] id;
        roll = $urandom_range(0, 99);
        id   = SLOT_W'($urandom());
        if (roll < 47)
        begin
            op = OP_ALLOC;
        end
        else if (roll < 90)
        begin
            op   = OP_RELEASE;
            pick = $urandom_range(0, 9);
            if (pick < 5 && recent_ids.size() > 0)
                id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
            else if (pick < 9)
                id = SLOT_W'($urandom_range(0, cap_seen + 2));
        end
        else if (roll < 97)
        begin
            op = OP_CLR_FLAG;
        end
        else
        begin
            op = OP_CLR_ALL;
        end
        issue_request(op, id, pick_gap());
    endtask

    initial
    begin
        int phase;
        int n;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of the chunk registers
        apb_access(1'b0, REG_FIRST_CHUNK, '0);
        apb_access(1'b0, REG_GROW_CHUNK, '0);

        // default chunks: range checks on empty, first growth, LIFO reuse, bad releases
        issue_request(OP_RELEASE, 16'h0000, pick_gap());
        issue_request(OP_RELEASE, 16'hFFFF, pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_CLR_FLAG, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_RELEASE, 16'd1, pick_gap());
        issue_request(OP_RELEASE, 16'd1, pick_gap());
        issue_request(OP_RELEASE, 16'd5, pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_RELEASE, 16'd4047, pick_gap());
        issue_request(OP_RELEASE, 16'd4048, pick_gap());
        issue_request(OP_CLR_ALL, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_RELEASE, 16'h0000, pick_gap());

        // zero chunks count as one
        set_chunks('0, '0);
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_CLR_FLAG, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_RELEASE, 16'd2, pick_gap());
        issue_request(OP_RELEASE, 16'd0, pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_RELEASE, 16'd3, pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());

        // oversized chunks: growth from zero clamps at the id limit
        set_chunks(17'h1FFFF, 17'h1FFFF);
        issue_request(OP_CLR_ALL, SLOT_W'($urandom()), 0);
        for (n = 0; n < 4; n++)
            issue_request(OP_ALLOC, SLOT_W'($urandom()), 0);
        issue_request(OP_RELEASE, 16'hFFFF, pick_gap());
        issue_request(OP_RELEASE, 16'hFFFF, pick_gap());
        issue_request(OP_RELEASE, 16'd1, pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_RELEASE, 16'h5555, pick_gap());
        issue_request(OP_RELEASE, 16'hAAAA, pick_gap());
        issue_request(OP_ALLOC, SLOT_W'($urandom()), pick_gap());
        issue_request(OP_CLR_ALL, SLOT_W'($urandom()), pick_gap());

        // random phases over several chunk settings
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       set_chunks(17'd1, 17'd1);
                1:       set_chunks(17'd3, 17'd2);
                2:       set_chunks(17'd65536, 17'd65536);
                3:       set_chunks(CHUNK_W'($urandom_range(2, 40)),
                                    CHUNK_W'($urandom_range(1, 16)));
                4:       set_chunks('0, 17'h1FFFF);
                default: set_chunks(CHUNK_W'($urandom_range(1, 300)),
                                    CHUNK_W'($urandom_range(0, 8)));
            endcase
            if (phase % 2 == 0)
                issue_request(OP_CLR_ALL, SLOT_W'($urandom()), pick_gap());
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                // hold off once until the block has answered everything
                if (phase == 1 && n == 120)
                    drain_requests(0);
                issue_random();
            end
        end

        drain_requests(SETTLE_CYCLES);
        if (fail_count == 0 && pending_count == 0)
            $display("chunked_free_list_id_allocator_unit regression: pass");
        else
            $display("chunked_free_list_id_allocator_unit regression: fail");
        $finish;
    end

endmodule

[chunked_free_list_id_allocator_unit.f]
sv/cfla_pkg.sv
sv/cfla_ram.sv
sv/cfla_regs.sv
sv/cfla_ctrl.sv
sv/cfla_dp.sv
sv/chunked_free_list_id_allocator_unit.sv
tb/sv/cfla_alloc_checker.sv
tb/sv/chunked_free_list_id_allocator_unit_test.sv
